@@ src/urlpe_pkg.sv @@
// urlpe_pkg: types, constants and character-class functions of the url percent encoder
// used by every module of the block; depends on nothing

package urlpe_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] MODE_HOST  = 2'd0;
	localparam logic [1:0] MODE_PATH  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_FULL  = 2'd3;
	localparam logic [1:0] MODE_RESET = MODE_FULL;

	localparam logic [7:0] CH_PERCENT  = 8'h25;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_F  = 8'h46;
	localparam logic [7:0] ASCII_MAX   = 8'd127;

	// one classified item in the queue between front and back
	typedef struct packed {
		logic [7:0] data;
		logic       eot;
		logic       esc;
	} urlpe_item_t;

	// back-end sequencer phases
	typedef enum logic [1:0] {
		PH_FIRST,
		PH_HI,
		PH_LO
	} urlpe_phase_t;

	function automatic logic is_unreserved(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
			8'h2D, 8'h2E, 8'h5F, 8'h7E});
	endfunction

	function automatic logic is_sub_delim(input logic [7:0] c);
		return (c inside {8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
			8'h2B, 8'h2C, 8'h3B, 8'h3D});
	endfunction

	function automatic logic is_gen_delim(input logic [7:0] c);
		return (c inside {8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40});
	endfunction

	function automatic logic path_allows(input logic [7:0] c);
		return is_unreserved(c) || is_sub_delim(c) || (c inside {8'h2F, 8'h3A, 8'h40});
	endfunction

	function automatic logic needs_escape(input logic [7:0] c, input logic [1:0] mode);
		logic esc;
		case (mode)
			MODE_HOST: esc = (c > ASCII_MAX);
			MODE_PATH: esc = !path_allows(c) || (c == CH_PERCENT) || (c == CH_PLUS);
			MODE_QUERY: esc = !(path_allows(c) || (c == CH_QUESTION))
				|| (c == CH_PERCENT) || (c == CH_PLUS);
			default: esc = !is_unreserved(c) && !(is_gen_delim(c) || is_sub_delim(c));
		endcase
		return esc;
	endfunction

	// uppercase hex digit of a nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] d;
		if (n < 4'd10) begin
			d = CH_ZERO + {4'd0, n};
		end else begin
			d = CH_UPPER_A + {4'd0, n} - 8'd10;
		end
		return d;
	endfunction

endpackage

@@ src/urlpe_classify.sv @@
// urlpe_classify: front end, holds the mode register and tags each input item as
// passed or escaped; depends on urlpe_pkg

module urlpe_classify (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_wdata,
	input  logic                 in_valid,
	input  logic [7:0]           in_data,
	input  logic                 in_last,
	output logic                 push,
	output urlpe_pkg::urlpe_item_t push_item,
	input  logic                 push_ready
);
	import urlpe_pkg::*;

	logic [1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	assign push           = in_valid && push_ready;
	assign push_item.data = in_data;
	assign push_item.eot  = in_last;
	assign push_item.esc  = needs_escape(in_data, mode_q);

endmodule

@@ src/urlpe_fifo.sv @@
// urlpe_fifo: short queue of classified items between front and back end
// depends on urlpe_pkg

module urlpe_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  urlpe_pkg::urlpe_item_t push_item,
	output logic                   ready,
	input  logic                   pop,
	output logic                   head_valid,
	output urlpe_pkg::urlpe_item_t head_item
);
	import urlpe_pkg::*;

	urlpe_item_t          slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic [FIFO_CW-1:0]   count_nxt;
	logic                 ready_q;
	logic                 do_pop;

	assign do_pop     = pop && (count_q != '0);
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign ready      = ready_q;

	always_comb begin
		count_nxt = count_q;
		if (push && !do_pop) begin
			count_nxt = count_q + FIFO_CW'(1);
		end else if (!push && do_pop) begin
			count_nxt = count_q - FIFO_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			ready_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_nxt;
			ready_q <= (count_nxt != FIFO_CW'(FIFO_DEPTH));
		end
	end

endmodule

@@ src/urlpe_emit.sv @@
// urlpe_emit: back end, expands each queued item into one or three output bytes
// through a registered output stage; depends on urlpe_pkg

module urlpe_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  urlpe_pkg::urlpe_item_t head_item,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_data,
	output logic                   out_run_last,
	output logic                   out_eot
);
	import urlpe_pkg::*;

	urlpe_phase_t state_q;
	urlpe_phase_t state_nxt;
	logic         valid_q;
	logic [7:0]   data_q;
	logic         run_last_q;
	logic         eot_q;
	logic         advance;
	logic [7:0]   data_nxt;
	logic         run_last_nxt;

	assign advance = head_valid && (!valid_q || out_ready);

	always_comb begin
		state_nxt    = state_q;
		data_nxt     = head_item.data;
		run_last_nxt = 1'b1;
		pop          = 1'b0;
		case (state_q)
			PH_FIRST: begin
				if (head_item.esc) begin
					data_nxt     = CH_PERCENT;
					run_last_nxt = 1'b0;
					if (advance) begin
						state_nxt = PH_HI;
					end
				end else begin
					pop = advance;
				end
			end
			PH_HI: begin
				data_nxt     = hex_digit(head_item.data[7:4]);
				run_last_nxt = 1'b0;
				if (advance) begin
					state_nxt = PH_LO;
				end
			end
			PH_LO: begin
				data_nxt = hex_digit(head_item.data[3:0]);
				pop      = advance;
				if (advance) begin
					state_nxt = PH_FIRST;
				end
			end
			default: begin
				state_nxt = PH_FIRST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_FIRST;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q     <= data_nxt;
			run_last_q <= run_last_nxt;
			eot_q      <= run_last_nxt && head_item.eot;
		end
	end

	assign out_valid    = valid_q;
	assign out_data     = data_q;
	assign out_run_last = run_last_q;
	assign out_eot      = eot_q;

endmodule

@@ src/url_percent_encoder_top.sv @@
// url_percent_encoder_top: top level of the url percent encoder
// depends on urlpe_pkg, urlpe_classify, urlpe_fifo and urlpe_emit
//
//  channel   | direction | payload                                   | accepted when
//  ----------+-----------+-------------------------------------------+------------------------
//  s_axis    | in        | tdata = in_byte, tlast = end_of_text      | tvalid && tready
//  m_axis    | out       | tdata = out_byte, tuser = last_of_run,    | tvalid && tready
//            |           | tlast = end_of_text_out                   |
//  cfg       | in        | cfg_wdata = encode_mode                   | cfg_we
//
// one output byte per cycle while m_axis_tready is high, set by the single output register
// of the back end; a passed byte gives one byte, an escaped one '%', high digit, low digit
// input items are taken every cycle while the four-entry queue has room
// reset clears the queue, the sequencer and the output valid; encode_mode resets to full
// s_axis_tready is registered: it is low during reset and rises in the cycle after release
// a stall on m_axis holds the output byte and fills the queue, then drops s_axis_tready

module url_percent_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,     // encode_mode
	// input stream
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,  // end_of_text
	// output stream
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tuser,  // [0] last_of_run
	output logic       m_axis_tlast   // end_of_text_out
);
	import urlpe_pkg::*;

	logic        push;
	urlpe_item_t push_item;
	logic        q_ready;
	logic        pop;
	logic        head_valid;
	urlpe_item_t head_item;

	// front: mode register and byte classification
	urlpe_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_axis_tvalid),
		.in_data    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.push       (push),
		.push_item  (push_item),
		.push_ready (q_ready)
	);

	// queue decouples the input side from the expansion
	urlpe_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.ready      (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// back: expansion into one or three bytes
	urlpe_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (m_axis_tdata),
		.out_run_last (m_axis_tuser),
		.out_eot      (m_axis_tlast)
	);

	assign s_axis_tready = q_ready;

endmodule

@@ src/urlpe_checker.sv @@
// urlpe_checker: port-level checks of the url percent encoder, bound to the top level
// depends on urlpe_pkg and url_percent_encoder_top

module urlpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser,
	input logic       m_axis_tlast
);
	import urlpe_pkg::*;

	// a stalled output item holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// end of text only on the final byte of a run
	a_eot_on_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("end of text on a byte that does not end its run");

	// bytes inside a run are '%' or uppercase hex digits
	a_inner_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			(m_axis_tdata == CH_PERCENT)
			|| (m_axis_tdata >= CH_ZERO && m_axis_tdata <= CH_NINE)
			|| (m_axis_tdata >= CH_UPPER_A && m_axis_tdata <= CH_UPPER_F))
		else $error("byte inside an escape run is not '%%' or a hex digit");

endmodule

bind url_percent_encoder_top urlpe_checker u_urlpe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

@@ sim/url_encode_checker.sv @@
// url_encode_checker: predicts the escaped byte stream of the url percent encoder and
// compares every output item against it; depends on urlpe_pkg for the mode codes

module url_encode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int unsigned mismatches,
	output int unsigned awaiting
);
	import urlpe_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       run_end;
		logic       text_end;
	} enc_byte_t;

	// digit n sits at bits [8*(15-n) +: 8]
	localparam logic [127:0] HEX_ASCII = "0123456789ABCDEF";

	enc_byte_t   encoded_q[$];
	logic [1:0]  mode_copy = MODE_RESET;
	int unsigned miss_count = 0;
	int unsigned queue_depth = 0;

	assign mismatches = miss_count;
	assign awaiting = queue_depth;

	function automatic logic plain_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")
			|| c == "-" || c == "." || c == "_" || c == "~";
	endfunction

	function automatic logic subdelim_char(input logic [7:0] c);
		logic hit;
		case (c)
			"!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=": hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic gendelim_char(input logic [7:0] c);
		logic hit;
		case (c)
			":", "/", "?", "#", "[", "]", "@": hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic must_escape(input logic [7:0] c, input logic [1:0] mode);
		logic path_ok;
		logic esc;
		path_ok = plain_char(c) || subdelim_char(c) || c == "/" || c == ":" || c == "@";
		case (mode)
			MODE_HOST: esc = c[7];
			MODE_PATH: esc = !path_ok || c == "%" || c == "+";
			MODE_QUERY: esc = !(path_ok || c == "?") || c == "%" || c == "+";
			default: esc = !(plain_char(c) || gendelim_char(c) || subdelim_char(c));
		endcase
		return esc;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return HEX_ASCII[(15 - int'(n)) * 8 +: 8];
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("url_encode_checker: %s", msg);
		miss_count++;
	endtask

	// add one predicted byte at the tail
	task automatic queue_byte(input enc_byte_t b);
		encoded_q = {encoded_q, b};
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		enc_byte_t want;
		if (!arst_n) begin
			encoded_q.delete();
			mode_copy = MODE_RESET;
			queue_depth = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (encoded_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected output item %02h", m_tdata));
				end else begin
					want = encoded_q.pop_front();
					if (m_tdata !== want.value)
						flag_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want.value));
					if (m_tuser !== want.run_end)
						flag_mismatch($sformatf("last_of_run %b, want %b on byte %02h",
							m_tuser, want.run_end, want.value));
					if (m_tlast !== want.text_end)
						flag_mismatch($sformatf("end_of_text_out %b, want %b on byte %02h",
							m_tlast, want.text_end, want.value));
				end
			end
			if (s_tvalid && s_tready) begin
				if (must_escape(s_tdata, mode_copy)) begin
					queue_byte('{value: "%", run_end: 1'b0, text_end: 1'b0});
					queue_byte('{value: hex_char(s_tdata[7:4]), run_end: 1'b0,
						text_end: 1'b0});
					queue_byte('{value: hex_char(s_tdata[3:0]), run_end: 1'b1,
						text_end: s_tlast});
				end else begin
					queue_byte('{value: s_tdata, run_end: 1'b1, text_end: s_tlast});
				end
			end
			if (cfg_we)
				mode_copy = cfg_wdata;
			queue_depth = encoded_q.size();
		end
	end

endmodule

@@ sim/tb_url_percent_encoder_top.sv @@
// tb_url_percent_encoder_top: stimulus, clock, reset and verdict for the url percent encoder
// depends on urlpe_pkg, url_percent_encoder_top and url_encode_checker

module tb_url_percent_encoder_top;
	import urlpe_pkg::*;

	// the slowest legal run stays far below this limit, which leaves plenty of margin
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 286;

	// directed bytes, four groups of six: full (reset value), host, path, query
	// first byte sits in the top bits
	localparam logic [8*24-1:0] EDGE_CHARS = {
		"#[%", 8'h80, "~", 8'h00,
		8'h7F, 8'h80, 8'hFF, " %", 8'h00,
		"+%?@/", 8'hFF,
		"?+#=a", 8'hC3
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	int unsigned mismatches;
	int unsigned awaiting;
	int unsigned cycle_count = 0;

	url_percent_encoder_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// watches both channels and the config port, counts mismatches
	url_encode_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tlast    (s_axis_tlast),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.m_tlast    (m_axis_tlast),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: a hung handshake or a lost result ends up here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_url_percent_encoder_top: errors");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 10);
		else
			return $urandom_range(15, 40);
	endfunction

	// output side back-pressure: ready runs of random length, some long runs
	// without any stall, separated by stalls from gap_len
	initial begin : sink_pacing
		int unsigned run;
		m_axis_tready = 1'b0;
		@(negedge clk);
		forever begin
			m_axis_tready = 1'b1;
			run = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 80) : $urandom_range(1, 8);
			repeat (run) @(negedge clk);
			run = gap_len();
			if (run != 0) begin
				m_axis_tready = 1'b0;
				repeat (run) @(negedge clk);
			end
		end
	end

	// offer one item, called at a falling edge and returns at a falling edge;
	// tvalid stays high afterwards so back-to-back items need no extra step
	task automatic send_char(input logic [7:0] ch, input logic eot, input logic no_gap);
		int unsigned gap;
		gap = no_gap ? 0 : gap_len();
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = ch;
		s_axis_tlast = eot;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	// hold the sender until the checker has seen every predicted result
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (awaiting != 0)
			@(negedge clk);
	endtask

	// encode_mode may only change while the encoder is empty
	task automatic set_mode(input logic [1:0] mode);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = mode;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin : stimulus
		int unsigned sent;
		int unsigned phase;
		int unsigned phase_items;
		int unsigned len;
		int unsigned k;
		logic        quiet;
		logic [7:0]  ch;
		logic [1:0]  mode;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = MODE_RESET;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tlast = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: class boundaries per mode, '%' '+' '?' and bytes above 127
		for (k = 0; k < 24; k++) begin
			case (k)
				6: set_mode(MODE_HOST);
				12: set_mode(MODE_PATH);
				18: set_mode(MODE_QUERY);
				default: ;
			endcase
			send_char(EDGE_CHARS[8 * (23 - k) +: 8], (k % 3) == 2, 1'b0);
		end

		// random part: strings of random content, each closed by end_of_text,
		// with a stray end_of_text now and then; every phase sets the mode anew,
		// the first four phases walk all modes from full down to host
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = (phase < 4) ? 2'(3 - phase) : 2'($urandom_range(0, 3));
			set_mode(mode);
			phase_items = 0;
			while (phase_items < 30 && sent < RANDOM_ITEMS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				if (len > RANDOM_ITEMS - sent)
					len = RANDOM_ITEMS - sent;
				quiet = ($urandom_range(0, 4) == 0);
				for (k = 0; k < len; k++) begin
					// mostly printable ascii, where the classes differ; the rest any byte
					ch = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(8'h20, 8'h7E))
						: 8'($urandom_range(0, 255));
					send_char(ch, (k == len - 1) || ($urandom_range(0, 19) == 0), quiet);
					sent++;
					phase_items++;
				end
			end
			phase++;
		end

		// let every predicted byte come out, then a short tail for strays
		drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && awaiting == 0) begin
			$display("tb_url_percent_encoder_top: clean");
		end else begin
			$display("tb_url_percent_encoder_top: errors");
		end
		$finish;
	end

endmodule
